[rtl/rpn_pkg.sv]
// Package for the RPN stack evaluator: word layouts, token and result codes,
// stack sizing constants. No dependencies.
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DATA_W      = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // token kinds
   localparam logic [2:0] MODE_PUSH  = 3'd0;
   localparam logic [2:0] MODE_ADD   = 3'd1;
   localparam logic [2:0] MODE_SUB   = 3'd2;
   localparam logic [2:0] MODE_MUL   = 3'd3;
   localparam logic [2:0] MODE_DIV   = 3'd4;
   localparam logic [2:0] MODE_PRINT = 3'd5;
   localparam logic [2:0] MODE_END   = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_ELEM = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_PRINT_EMPTY = 3'd1;
   localparam logic [2:0] ERR_UNDERFLOW   = 3'd2;
   localparam logic [2:0] ERR_DIV_ZERO    = 3'd3;
   localparam logic [2:0] ERR_FINAL_COUNT = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [DATA_W-1:0] number;
   } req_word_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] element;
      logic [2:0]               error_code;
      logic                     last;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/rpn_stack_ram.sv]
// Synchronous single-write, single-read RAM with registered read data.
// Holds the operand stack entries below the top of stack. No dependencies.
`default_nettype none

module rpn_stack_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/rpn_divider.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for the data width.
`default_nettype none

module rpn_divider
   import rpn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   done,
   output logic      [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         // take magnitudes; the most negative value maps to itself as unsigned
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         dsr_in  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

endmodule

`default_nettype wire

[rtl/rpn_stack_evaluator_unit.sv]
// Top level of the RPN stack evaluator: token sequencer, top-of-stack register,
// result register. Depends on rpn_pkg, rpn_stack_ram and rpn_divider.
//
// Usage:
//   req channel (req_valid / req_stall / req_word) carries one token per word:
//   push, add, subtract, multiply, divide, print or end. rsp channel
//   (rsp_valid / rsp_stall / rsp_word) returns printed elements, the final
//   value, or one error word. A word moves when valid is high and stall low.
//   The top of stack lives in a register; the entries below it live in a
//   synchronous RAM with one read port, so an operator needs one read and a
//   print reads one entry per element below the top.
// Steps per token:
//   push, end, and print of one element: taken and done in the idle state.
//   add, subtract, multiply: RAM read, then execute.
//   divide: RAM read, start, 32 one-bit divider steps, writeback.
//   print of N elements: a RAM read, then a word, per entry below the top; then the top.
// Result latency: the result register loads in the cycle the word is decided;
//   it is visible the cycle after.
// Reset (synchronous, active high) empties the stack and clears the halt flag;
//   stack RAM contents are not cleared and never read before written.
// When rsp_stall holds, the result word holds and the idle and print states wait;
//   no token is taken until that word leaves, even one that gives no result.
// After an error or an end token the block halts: tokens are taken and dropped
//   until reset.
`default_nettype none

module rpn_stack_evaluator_unit
   import rpn_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP,
      ST_DIV,
      ST_PRINT_RD,
      ST_PRINT_WR,
      ST_PRINT_TOP
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              halted_ff, halted_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [2:0]        op_ff, op_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              rsp_free;
   logic              req_accept;
   logic              rsp_load;

   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;

   logic [CNT_W-1:0]  count_dec;
   logic [CNT_W-1:0]  count_dec2;
   logic [2*DATA_W-1:0] product;

   // result register can take a new word this cycle
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign count_dec  = count_ff - CNT_W'(1);
   assign count_dec2 = count_ff - CNT_W'(2);
   assign product    = {{DATA_W{1'b0}}, ram_rd_data} * {{DATA_W{1'b0}}, top_ff};

   rpn_stack_ram #(
      .DEPTH(STACK_DEPTH),
      .WIDTH(DATA_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(top_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   rpn_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(ram_rd_data),
      .divisor (top_ff),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      halted_in   = halted_ff;
      top_in      = top_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      rsp_load    = 1'b0;
      rsp_word_in = rsp_word_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_dec[PTR_W-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = count_dec2[PTR_W-1:0];
      div_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !halted_ff) begin
               // default to an error word; arms below override or drop it
               rsp_word_in.kind       = KIND_ERR;
               rsp_word_in.element    = '0;
               rsp_word_in.last       = 1'b1;
               rsp_word_in.error_code = ERR_NONE;
               case (req_word.mode) inside
                  MODE_PUSH: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_word_in.error_code = ERR_OVERFLOW;
                        rsp_load  = 1'b1;
                        halted_in = 1'b1;
                     end else begin
                        // spill the old top below the new one
                        ram_wr_en = (count_ff != '0);
                        top_in    = req_word.number;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_word_in.error_code = ERR_UNDERFLOW;
                        rsp_load  = 1'b1;
                        halted_in = 1'b1;
                     end else if (req_word.mode == MODE_DIV && top_ff == '0) begin
                        rsp_word_in.error_code = ERR_DIV_ZERO;
                        rsp_load  = 1'b1;
                        halted_in = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        op_in     = req_word.mode;
                        state_in  = ST_OP;
                     end
                  end
                  MODE_PRINT: begin
                     if (count_ff == '0) begin
                        rsp_word_in.error_code = ERR_PRINT_EMPTY;
                        rsp_load  = 1'b1;
                        halted_in = 1'b1;
                     end else if (count_ff == CNT_W'(1)) begin
                        rsp_word_in.kind    = KIND_ELEM;
                        rsp_word_in.element = top_ff;
                        rsp_load            = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_PRINT_RD;
                     end
                  end
                  MODE_END: begin
                     if (count_ff == CNT_W'(1)) begin
                        rsp_word_in.kind    = KIND_DONE;
                        rsp_word_in.element = top_ff;
                     end else begin
                        rsp_word_in.error_code = ERR_FINAL_COUNT;
                     end
                     rsp_load  = 1'b1;
                     halted_in = 1'b1;
                  end
                  default: begin
                     // undefined token: drop it
                  end
               endcase
            end
         end
         ST_OP: begin
            // ram_rd_data is the second entry, top_ff the top
            state_in = ST_IDLE;
            count_in = count_dec;
            case (op_ff)
               MODE_ADD: top_in = ram_rd_data + top_ff;
               MODE_SUB: top_in = ram_rd_data - top_ff;
               MODE_MUL: top_in = product[DATA_W-1:0];
               default: begin
                  div_start = 1'b1;
                  count_in  = count_ff;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               top_in   = div_quotient;
               count_in = count_dec;
               state_in = ST_IDLE;
            end
         end
         ST_PRINT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
            state_in    = ST_PRINT_WR;
         end
         ST_PRINT_WR: begin
            if (rsp_free) begin
               rsp_load               = 1'b1;
               rsp_word_in.kind       = KIND_ELEM;
               rsp_word_in.element    = ram_rd_data;
               rsp_word_in.error_code = ERR_NONE;
               rsp_word_in.last       = 1'b0;
               idx_in                 = idx_ff + PTR_W'(1);
               if (idx_ff == count_dec2[PTR_W-1:0]) begin
                  state_in = ST_PRINT_TOP;
               end else begin
                  state_in = ST_PRINT_RD;
               end
            end
         end
         ST_PRINT_TOP: begin
            if (rsp_free) begin
               rsp_load               = 1'b1;
               rsp_word_in.kind       = KIND_ELEM;
               rsp_word_in.element    = top_ff;
               rsp_word_in.error_code = ERR_NONE;
               rsp_word_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff <= top_in;
      op_ff  <= op_in;
      idx_ff <= idx_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

[rtl/rpn_checker.sv]
// Port-level assertions for the RPN stack evaluator and the bind that attaches
// them to the top level. Depends on rpn_pkg.
`default_nettype none

module rpn_checker
   import rpn_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_word_type req_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // error words carry zero and close the burst
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind == KIND_ERR) |->
         (rsp_word.element == '0 && rsp_word.last && rsp_word.error_code != ERR_NONE))
      else $error("malformed error word");

   // only error words carry a code
   a_code_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind != KIND_ERR) |-> (rsp_word.error_code == ERR_NONE))
      else $error("error code on a non-error word");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("result word changed under stall");

endmodule

bind rpn_stack_evaluator_unit rpn_checker u_rpn_checker (.*);

`default_nettype wire
